// File: sv/pbi_pkg.sv
package pbi_pkg;

    // Fixed geometry of the slot file
    localparam int MAX_BLOCK   = 16;
    localparam int SLOT_BITS   = 4;
    localparam int HANDLE_BITS = 16;
    localparam int BSIZE_BITS  = 5;

    localparam logic [BSIZE_BITS-1:0] BSIZE_RESET = BSIZE_BITS'(MAX_BLOCK);

    // Input word action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    typedef logic [SLOT_BITS-1:0]   t_slot;
    typedef logic [HANDLE_BITS-1:0] t_handle;

    // Slot RAM access from the sequencer
    typedef struct packed {
        logic    we;
        t_slot   waddr;
        t_handle wdata;
        logic    re;
        t_slot   raddr;
    } t_ram_req;

    // Result push toward the output register
    typedef struct packed {
        logic valid;
        logic last;
    } t_push;

endpackage

// File: sv/pbi_in_if.sv
interface pbi_in_if import pbi_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    t_handle     packet_handle;
    t_slot       order_index;
    t_slot       order_slot;

    modport source(output valid, action, packet_handle, order_index, order_slot,
                   input ready);
    modport sink(input valid, action, packet_handle, order_index, order_slot,
                 output ready);
endinterface

// File: sv/pbi_out_if.sv
interface pbi_out_if import pbi_pkg::*;;
    logic    valid;
    logic    ready;
    t_handle out_handle;
    logic    last_of_run;

    modport source(output valid, out_handle, last_of_run, input ready);
    modport sink(input valid, out_handle, last_of_run, output ready);
endinterface

// File: sv/pbi_slot_ram.sv
module pbi_slot_ram import pbi_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_handle  o_rd_data
);

    t_handle r_mem [MAX_BLOCK];
    t_handle r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/pbi_ctrl.sv
module pbi_ctrl import pbi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BSIZE_BITS-1:0] i_cfg_wdata,
    pbi_in_if.sink                i_in,
    input  logic                  i_out_free,
    output t_ram_req              o_ram_req,
    output t_push                 o_push
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [BSIZE_BITS-1:0] r_bsize;
    logic [MAX_BLOCK-1:0]  r_full;
    t_slot                 r_order [MAX_BLOCK];
    t_slot                 r_put_ptr, n_put_ptr;
    t_slot                 r_send_ptr, n_send_ptr;
    logic                  r_pend, n_pend;

    logic [BSIZE_BITS-1:0] eff_size;
    t_slot                 scan_slot;
    t_slot                 low_slot;
    logic                  any_full;
    logic                  busy;
    logic                  found;
    logic                  stall;
    logic                  step;
    logic                  accept;
    t_slot                 rd_slot;

    // Pointer increment, wrapping at the effective block size
    function automatic t_slot f_advance(input t_slot p, input logic [BSIZE_BITS-1:0] sz);
        logic [SLOT_BITS:0] inc;
        t_slot              nxt;
        inc = {1'b0, p} + (SLOT_BITS+1)'(1);
        nxt = inc[SLOT_BITS-1:0];
        if ({1'b0, nxt} >= sz) begin
            nxt = '0;
        end
        return nxt;
    endfunction

    // Block size clamped to 1..MAX_BLOCK
    always_comb begin
        if (r_bsize == '0) begin
            eff_size = BSIZE_BITS'(1);
        end else if (r_bsize > BSIZE_RESET) begin
            eff_size = BSIZE_RESET;
        end else begin
            eff_size = r_bsize;
        end
    end

    // Lowest full slot for flush
    always_comb begin
        low_slot = '0;
        for (int i = MAX_BLOCK - 1; i >= 0; i--) begin
            if (r_full[i]) begin
                low_slot = SLOT_BITS'(i);
            end
        end
    end

    assign any_full  = |r_full;
    assign scan_slot = r_order[r_send_ptr];
    assign busy      = (r_state == ST_SCAN) || (r_state == ST_FLUSH);

    always_comb begin
        case (r_state)
            ST_SCAN:  found = r_full[scan_slot];
            ST_FLUSH: found = any_full;
            default:  found = 1'b0;
        endcase
    end

    assign rd_slot    = (r_state == ST_SCAN) ? scan_slot : low_slot;
    // Held result waits for the output register before the next read
    assign stall      = r_pend && !i_out_free;
    assign step       = busy && !stall;
    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Pending word goes out once we know whether another follows
    assign o_push.valid = step && r_pend;
    assign o_push.last  = !found;

    always_comb begin
        o_ram_req.we    = accept && (i_in.action == ACT_WRITE);
        o_ram_req.waddr = r_put_ptr;
        o_ram_req.wdata = i_in.packet_handle;
        o_ram_req.re    = step && found;
        o_ram_req.raddr = rd_slot;
    end

    // Sequencer and pointer updates
    always_comb begin
        n_state    = r_state;
        n_put_ptr  = r_put_ptr;
        n_send_ptr = r_send_ptr;
        n_pend     = r_pend;
        if (accept) begin
            case (i_in.action)
                ACT_WRITE: begin
                    n_put_ptr = f_advance(r_put_ptr, eff_size);
                    n_state   = ST_SCAN;
                end
                ACT_FLUSH: begin
                    n_put_ptr  = '0;
                    n_send_ptr = '0;
                    n_state    = ST_FLUSH;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end else if (step) begin
            n_pend = found;
            if (!found) begin
                n_state = ST_IDLE;
            end else if (r_state == ST_SCAN) begin
                n_send_ptr = f_advance(r_send_ptr, eff_size);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_bsize    <= BSIZE_RESET;
            r_full     <= '0;
            r_put_ptr  <= '0;
            r_send_ptr <= '0;
            r_pend     <= 1'b0;
            for (int i = 0; i < MAX_BLOCK; i++) begin
                r_order[i] <= SLOT_BITS'(i);
            end
        end else begin
            r_state    <= n_state;
            r_put_ptr  <= n_put_ptr;
            r_send_ptr <= n_send_ptr;
            r_pend     <= n_pend;
            if (i_cfg_we) begin
                r_bsize <= i_cfg_wdata;
            end
            if (accept && (i_in.action == ACT_LOAD)) begin
                r_order[i_in.order_index] <= i_in.order_slot;
            end
            // Fill on write, drain on read
            if (o_ram_req.we) begin
                r_full[r_put_ptr] <= 1'b1;
            end
            if (o_ram_req.re) begin
                r_full[rd_slot] <= 1'b0;
            end
        end
    end

endmodule

// File: sv/packet_block_interleaver.sv
// Packet block interleaver: a write stores its handle in the next of the configured number of
// slots and then releases, in send-order-table sequence, each handle whose slot is full, up to
// the first empty slot; a load sets one send-order entry, a flush drains all full slots in
// ascending slot order and zeroes both pointers. A write or flush that releases N handles
// (N from 0 to 16) then holds the input off while it makes one slot RAM read per released
// word and one more read step that finds no full slot, and while a finished word waits in a
// full output register; the last word of each run is marked by last_of_run. A load or an
// unused action code returns the block straight to idle. An output register lets the next input
// word be taken while a result still waits downstream.
module packet_block_interleaver import pbi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BSIZE_BITS-1:0] i_cfg_wdata,
    pbi_in_if.sink                i_in,
    pbi_out_if.source             o_out
);

    t_ram_req ram_req;
    t_push    push;
    t_handle  rd_data;
    logic     out_free;

    logic     r_out_valid;
    t_handle  r_out_handle;
    logic     r_out_last;

    pbi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_out_free  (out_free),
        .o_ram_req   (ram_req),
        .o_push      (push)
    );

    pbi_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_out_valid || o_out.ready;

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out_handle <= rd_data;
            r_out_last   <= push.last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_handle  = r_out_handle;
    assign o_out.last_of_run = r_out_last;

    // A push never overwrites a word that has not been taken
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> out_free)
        else $error("result pushed into occupied output register");

    // A write always starts a scan, so input is held off the next cycle
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.action == ACT_WRITE) |=> !i_in.ready)
        else $error("input taken right after a write");

    // No slot read or push while idle waiting for input
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!ram_req.re && !push.valid))
        else $error("slot read or push while idle");

endmodule
